@@ design/nlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_pkg: shared definitions for the normalized Legendre table
// Widths, fixed-point formats, command and status types, and the two
// coefficient ROMs that are built at elaboration time.
// ----------------------------------------------------------------------------
package nlt_pkg;

    localparam int MAX_DEGREE      = 9;
    localparam int ARG_FRAC_BITS   = 30;
    localparam int VALUE_FRAC_BITS = 26;
    localparam int COEF_FRAC       = 28;

    localparam int DEG_W   = 4;
    localparam int ARG_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COEF_W  = COEF_FRAC + 3;
    localparam int MUL_W   = ARG_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ROOT_W  = ARG_FRAC_BITS + 1;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int CNT_W   = $clog2(ROOT_STEPS);
    localparam int VRND_W  = PROD_W - COEF_FRAC;

    localparam logic [DEG_W-1:0] TOP_DEGREE_RESET = DEG_W'(9);
    localparam logic [DEG_W-1:0] TOP_DEGREE_MAX   = DEG_W'(MAX_DEGREE);

    localparam logic signed [ARG_W-1:0]  ARG_ONE = ARG_W'(1) <<< ARG_FRAC_BITS;
    localparam logic signed [VAL_W-1:0]  VAL_ONE = VAL_W'(1) <<< VALUE_FRAC_BITS;
    localparam logic [RAD_W-1:0]         RAD_ONE = RAD_W'(1) << (2 * ARG_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] U_HALF  = PROD_W'(1) <<< (ARG_FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] V_HALF  = PROD_W'(1) <<< (COEF_FRAC - 1);

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ,
        MUL_XA,
        MUL_BP2,
        MUL_UP1
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic             load_arg;
        t_mul_op          mul_op;
        t_acc_op          acc_op;
        logic             root_init;
        logic             root_step;
        logic             load_u;
        logic             emit_p00;
        logic             emit_val;
        logic             diag;
        logic [DEG_W-1:0] rom_n;
        logic [DEG_W-1:0] rom_m;
        logic [DEG_W-1:0] out_n;
        logic [DEG_W-1:0] out_m;
        logic             out_last;
    } t_nlt_cmd;

    typedef struct packed {
        logic out_free;
    } t_nlt_status;

    typedef logic [MAX_DEGREE:0][MAX_DEGREE:0][COEF_W-1:0] t_coef_rom;

    // round(sqrt(num/den) * 2^COEF_FRAC): the largest y with
    // y*y*den <= num * 2^(2*COEF_FRAC+2), then halved with rounding.
    function automatic logic [COEF_W-1:0] rom_coef(input int unsigned num,
                                                   input int unsigned den);
        logic [127:0] lim;
        logic [127:0] y;
        logic [127:0] trial;
        lim = 128'(num) << (2 * COEF_FRAC + 2);
        y   = '0;
        for (int i = COEF_FRAC + 5; i >= 0; i--) begin
            trial = y | (128'(1) << i);
            if (trial * trial * 128'(den) <= lim) begin
                y = trial;
            end
        end
        return COEF_W'((y + 128'(1)) >> 1);
    endfunction

    // Multiplier of the newest value: d(m) on the diagonal, e(m) just
    // below it, a(n,m) elsewhere.
    function automatic t_coef_rom build_rom_a();
        t_coef_rom   rom;
        int unsigned num;
        int unsigned den;
        rom = '0;
        for (int n = 0; n <= MAX_DEGREE; n++) begin
            for (int m = 0; m <= n; m++) begin
                if (n == m) begin
                    if (m == 1) begin
                        rom[n][m] = rom_coef(3, 1);
                    end else if (m > 1) begin
                        rom[n][m] = rom_coef(int'(2 * m + 1), int'(2 * m));
                    end
                end else if (n == m + 1) begin
                    rom[n][m] = rom_coef(int'(2 * m + 3), 1);
                end else begin
                    num = int'((2 * n - 1) * (2 * n + 1));
                    den = int'((n - m) * (n + m));
                    rom[n][m] = rom_coef(num, den);
                end
            end
        end
        return rom;
    endfunction

    // Multiplier of the value two steps back; zero where the column starts.
    function automatic t_coef_rom build_rom_b();
        t_coef_rom   rom;
        int unsigned num;
        int unsigned den;
        rom = '0;
        for (int n = 2; n <= MAX_DEGREE; n++) begin
            for (int m = 0; m + 2 <= n; m++) begin
                num = int'((2 * n + 1) * (n + m - 1) * (n - m - 1));
                den = int'((2 * n - 3) * (n + m) * (n - m));
                rom[n][m] = rom_coef(num, den);
            end
        end
        return rom;
    endfunction

    localparam t_coef_rom ROM_A = build_rom_a();
    localparam t_coef_rom ROM_B = build_rom_b();

endpackage

@@ design/nlt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_if: stream channels of the normalized Legendre table
// One channel carries arguments in, the other carries table values out.
// ----------------------------------------------------------------------------
interface nlt_in_if;
    import nlt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ARG_W-1:0] argument;

    modport source (output valid, output argument, input ready);
    modport sink   (input valid, input argument, output ready);
endinterface

interface nlt_out_if;
    import nlt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [DEG_W-1:0]        degree;
    logic [DEG_W-1:0]        order;
    logic signed [VAL_W-1:0] value;
    logic                    last;

    modport source (output valid, output degree, output order, output value,
                    output last, input ready);
    modport sink   (input valid, input degree, input order, input value,
                    input last, output ready);
endinterface

@@ design/nlt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_datapath: arithmetic of the normalized Legendre table
// Shared multiplier, bitwise square root, rounding and saturation, the
// recurrence history and the output register.
// ----------------------------------------------------------------------------
module nlt_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nlt_pkg::t_nlt_cmd               i_cmd,
    input  logic signed [nlt_pkg::ARG_W-1:0] i_argument,
    input  logic                            i_out_ready,
    output nlt_pkg::t_nlt_status            o_status,
    output logic                            o_out_valid,
    output logic [nlt_pkg::DEG_W-1:0]       o_out_degree,
    output logic [nlt_pkg::DEG_W-1:0]       o_out_order,
    output logic signed [nlt_pkg::VAL_W-1:0] o_out_value,
    output logic                            o_out_last
);
    import nlt_pkg::*;

    logic signed [ARG_W-1:0]  r_t;
    logic [ROOT_W-1:0]        r_root;
    logic [REM_W-1:0]         r_rem;
    logic [RAD_W-1:0]         r_rad;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [VAL_W-1:0]  r_u;
    logic signed [VAL_W-1:0]  r_p1;
    logic signed [VAL_W-1:0]  r_p2;
    logic signed [VAL_W-1:0]  r_diag;
    logic                     r_out_valid;
    logic [DEG_W-1:0]         r_out_degree;
    logic [DEG_W-1:0]         r_out_order;
    logic signed [VAL_W-1:0]  r_out_value;
    logic                     r_out_last;

    logic signed [ARG_W-1:0]  t_clamped;
    logic [COEF_W-1:0]        coef_a;
    logic [COEF_W-1:0]        coef_b;
    logic                     x_is_sine;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] n_prod;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic signed [PROD_W-1:0] u_sum;
    logic signed [PROD_W-1:0] v_sum;
    logic signed [VRND_W-1:0] v_rnd;
    logic signed [VAL_W-1:0]  v_sat;
    logic                     out_free;

    always_comb begin
        if (i_argument > ARG_ONE) begin
            t_clamped = ARG_ONE;
        end else if (i_argument < -ARG_ONE) begin
            t_clamped = -ARG_ONE;
        end else begin
            t_clamped = i_argument;
        end
    end

    assign coef_a    = ROM_A[i_cmd.rom_n][i_cmd.rom_m];
    assign coef_b    = ROM_B[i_cmd.rom_n][i_cmd.rom_m];
    assign x_is_sine = (i_cmd.rom_n == i_cmd.rom_m);

    always_comb begin
        case (i_cmd.mul_op)
            MUL_SQ: begin
                mul_a = MUL_W'(r_t);
                mul_b = MUL_W'(r_t);
            end
            MUL_XA: begin
                mul_a = x_is_sine ? signed'(MUL_W'(r_root)) : MUL_W'(r_t);
                mul_b = signed'(MUL_W'(coef_a));
            end
            MUL_BP2: begin
                mul_a = signed'(MUL_W'(coef_b));
                mul_b = MUL_W'(r_p2);
            end
            MUL_UP1: begin
                mul_a = MUL_W'(r_u);
                mul_b = i_cmd.diag ? MUL_W'(r_diag) : MUL_W'(r_p1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Round half away from zero as a single add: negative values take
    // one less than half before the arithmetic shift.
    assign u_sum = r_prod + U_HALF - PROD_W'(r_prod[PROD_W-1]);
    assign v_sum = r_acc + V_HALF - PROD_W'(r_acc[PROD_W-1]);
    assign v_rnd = v_sum[PROD_W-1:COEF_FRAC];

    always_comb begin
        if (!v_rnd[VRND_W-1] && (|v_rnd[VRND_W-2:VAL_W-1])) begin
            v_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v_rnd[VRND_W-1] && !(&v_rnd[VRND_W-2:VAL_W-1])) begin
            v_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            v_sat = v_rnd[VAL_W-1:0];
        end
    end

    // One result bit of the square root per cycle.
    assign rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_arg) begin
            r_t <= t_clamped;
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= n_prod;
        end
        if (i_cmd.root_init) begin
            r_rad  <= RAD_ONE - r_prod[RAD_W-1:0];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load_u) begin
            r_u <= u_sum[ARG_FRAC_BITS +: VAL_W];
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_SUB:  r_acc <= r_prod - r_acc;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.emit_p00) begin
            r_p1   <= VAL_ONE;
            r_p2   <= '0;
            r_diag <= VAL_ONE;
        end else if (i_cmd.emit_val) begin
            if (i_cmd.diag) begin
                r_diag <= v_sat;
                r_p1   <= v_sat;
                r_p2   <= '0;
            end else begin
                r_p2 <= r_p1;
                r_p1 <= v_sat;
            end
        end
        if (i_cmd.emit_p00 || i_cmd.emit_val) begin
            r_out_degree <= i_cmd.out_n;
            r_out_order  <= i_cmd.out_m;
            r_out_last   <= i_cmd.out_last;
            r_out_value  <= i_cmd.emit_p00 ? VAL_ONE : v_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_p00 || i_cmd.emit_val) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_free          = !r_out_valid || i_out_ready;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_degree      = r_out_degree;
    assign o_out_order       = r_out_order;
    assign o_out_value       = r_out_value;
    assign o_out_last        = r_out_last;

endmodule

@@ design/nlt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_controller: sequencer of the normalized Legendre table
// Holds the top degree register, walks the table column by column and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module nlt_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nlt_pkg::DEG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  nlt_pkg::t_nlt_status        i_status,
    output nlt_pkg::t_nlt_cmd           o_cmd
);
    import nlt_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_RINIT = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_P00   = 4'd4;
    localparam logic [3:0] ST_T1    = 4'd5;
    localparam logic [3:0] ST_T2    = 4'd6;
    localparam logic [3:0] ST_T3    = 4'd7;
    localparam logic [3:0] ST_T4    = 4'd8;
    localparam logic [3:0] ST_T5    = 4'd9;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [DEG_W-1:0] r_top_degree;
    logic [DEG_W-1:0] r_n;
    logic [DEG_W-1:0] n_n;
    logic [DEG_W-1:0] r_m;
    logic [DEG_W-1:0] n_m;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic [DEG_W-1:0] eff_top;
    logic [DEG_W-1:0] nx_n;
    logic [DEG_W-1:0] nx_m;
    logic             is_last;

    assign eff_top = (r_top_degree > TOP_DEGREE_MAX) ? TOP_DEGREE_MAX : r_top_degree;
    assign is_last = (r_m == eff_top) && (r_n == eff_top);

    // Next entry: down the column, or onto the next diagonal.
    always_comb begin
        if (r_n < eff_top) begin
            nx_n = r_n + DEG_W'(1);
            nx_m = r_m;
        end else begin
            nx_n = r_m + DEG_W'(1);
            nx_m = r_m + DEG_W'(1);
        end
    end

    always_comb begin
        n_state        = r_state;
        n_n            = r_n;
        n_m            = r_m;
        n_cnt          = r_cnt;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_op   = MUL_NONE;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.rom_n    = r_n;
        o_cmd.rom_m    = r_m;
        o_cmd.diag     = (r_n == r_m);
        o_cmd.out_n    = r_n;
        o_cmd.out_m    = r_m;
        o_cmd.out_last = is_last;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_arg = 1'b1;
                    n_state        = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.mul_op = MUL_SQ;
                n_state      = ST_RINIT;
            end
            ST_RINIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = CNT_W'(ROOT_STEPS - 1);
                n_state         = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_P00;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_P00: begin
                o_cmd.out_n    = '0;
                o_cmd.out_m    = '0;
                o_cmd.out_last = (eff_top == '0);
                if (i_status.out_free) begin
                    o_cmd.emit_p00 = 1'b1;
                    n_n            = DEG_W'(1);
                    n_m            = '0;
                    n_state        = (eff_top == '0) ? ST_IDLE : ST_T1;
                end
            end
            ST_T1: begin
                o_cmd.mul_op = MUL_XA;
                n_state      = ST_T2;
            end
            ST_T2: begin
                o_cmd.load_u = 1'b1;
                o_cmd.mul_op = MUL_BP2;
                n_state      = ST_T3;
            end
            ST_T3: begin
                o_cmd.acc_op = ACC_LOAD;
                o_cmd.mul_op = MUL_UP1;
                n_state      = ST_T4;
            end
            ST_T4: begin
                o_cmd.acc_op = ACC_SUB;
                if (!is_last) begin
                    o_cmd.mul_op = MUL_XA;
                    o_cmd.rom_n  = nx_n;
                    o_cmd.rom_m  = nx_m;
                end
                n_state = ST_T5;
            end
            ST_T5: begin
                if (i_status.out_free) begin
                    o_cmd.emit_val = 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_n     = nx_n;
                        n_m     = nx_m;
                        n_state = ST_T2;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_top_degree <= TOP_DEGREE_RESET;
            r_n          <= '0;
            r_m          <= '0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_m     <= n_m;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_top_degree <= i_cfg_wdata;
            end
        end
    end

endmodule

@@ design/normalized_legendre_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_legendre_table: fully normalized associated Legendre values
// For one argument t the block returns every P(n,m), 0 <= m <= n <= top
// degree, column by column, with the final value flagged.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                        transfer when
//   -------  ---------  -----------------------------  -----------------------
//   i_in     in         argument (s32, 30 frac bits)   i_in.valid & i_in.ready
//   o_out    out        degree, order, value, last     o_out.valid & o_out.ready
//   cfg      in         i_cfg_wdata = top degree       i_cfg_we
//
// An argument is taken only while the block is idle. P(0,0) is loaded after
// the square of t and then a 31-step bitwise root of 1 - t*t.
// Each later value takes the steps T2 to T5 (the first one also T1) on
// the single shared 33x33 multiplier. Reset (synchronous, active low)
// idles the sequencer, empties the output register and sets the top
// degree to 9. An untaken output holds the emit step.
//
// Datapath arithmetic per value:
//   u = round(x * A(n,m), 30)       x is the sine term on the diagonal, else t
//   P = sat(round(u * P1 - B(n,m) * P2, 28))
// where P1 is the previous diagonal for a diagonal entry and the previous
// value of the column otherwise, and B is zero for the first two entries of
// each column. A and B come from ROMs built at elaboration.
// ----------------------------------------------------------------------------
module normalized_legendre_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nlt_pkg::DEG_W-1:0] i_cfg_wdata,
    nlt_in_if.sink                    i_in,
    nlt_out_if.source                 o_out
);
    import nlt_pkg::*;

    t_nlt_cmd    cmd;
    t_nlt_status status;

    // The sequencer owns the top degree register and the table walk.
    nlt_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the argument, the root, the recurrence history
    // and the output register that decouples the result channel.
    nlt_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_argument   (i_in.argument),
        .i_out_ready  (o_out.ready),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .o_out_degree (o_out.degree),
        .o_out_order  (o_out.order),
        .o_out_value  (o_out.value),
        .o_out_last   (o_out.last)
    );

    // A value is only ever loaded into a free output register.
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_val || cmd.emit_p00) |-> status.out_free)
        else $error("value loaded while output register busy");

    // Every offered value lies on or below the diagonal.
    a_order_le_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.order <= o_out.degree))
        else $error("order above degree");

    // After the flagged final value the block is ready for a new argument.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_val && cmd.out_last) |=> i_in.ready)
        else $error("not idle after final value");

    // While waiting for an argument the datapath is left alone.
    a_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (cmd.mul_op == MUL_NONE && !cmd.emit_val && !cmd.emit_p00))
        else $error("datapath busy while idle");

endmodule

@@ dv/tb_normalized_legendre_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normalized_legendre_table: self-checking bench for the Legendre table
// Feeds arguments through the input channel and checks every emitted P(n,m)
// against a bit-exact fixed-point predictor held in a scoreboard class. The
// run steps through several top degrees and several idling patterns.
// ----------------------------------------------------------------------------
module tb_normalized_legendre_table;
    import nlt_pkg::*;

    // Idling patterns of the two channels during a phase of the run.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int HEAVY_IDLE_PCT = 63;
    localparam int LIGHT_IDLE_PCT = 22;
    // The block returns to idle right after its last transfer, so a short
    // pause is enough before a register write.
    localparam int PAUSE_CYCLES   = 8;
    // Longer than a full degree-9 table takes, so that any stray transfer at
    // the end is caught.
    localparam int SETTLE_CYCLES  = 400;

    // Arguments at and around the edges of the valid range, including ones
    // that the block must clamp to plus or minus one.
    localparam int NUM_CORNERS = 14;
    localparam logic signed [ARG_W-1:0] CORNER_ARGS [NUM_CORNERS] = '{
        32'sh0000_0000,
        ARG_ONE,
        -ARG_ONE,
        32'sh0000_0001,
        -32'sh0000_0001,
        ARG_ONE - 32'sd1,
        -ARG_ONE + 32'sd1,
        ARG_ONE + 32'sd1,
        -ARG_ONE - 32'sd1,
        32'sh7FFF_FFFF,
        32'sh8000_0000,
        32'sh2000_0000,
        -32'sh2000_0000,
        32'sh2D41_3CCD
    };

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the whole table for each accepted argument and
    // matches the emitted values against it in order.
    // ------------------------------------------------------------------------
    class legendre_scoreboard;
        typedef struct {
            logic [DEG_W-1:0]        degree;
            logic [DEG_W-1:0]        order;
            logic signed [VAL_W-1:0] value;
            logic                    last;
        } t_table_entry;

        t_table_entry     expected_values[$];
        logic [DEG_W-1:0] top_degree;
        int unsigned      mismatches;

        // Recurrence coefficients with COEF_FRAC fraction bits.
        longint coef_d [MAX_DEGREE+1];
        longint coef_e [MAX_DEGREE+1];
        longint coef_a [MAX_DEGREE+1][MAX_DEGREE+1];
        longint coef_b [MAX_DEGREE+1][MAX_DEGREE+1];

        function new();
            top_degree = TOP_DEGREE_RESET;
            mismatches = 0;
            for (int m = 0; m <= MAX_DEGREE; m++) begin
                coef_d[m] = 0;
                if (m == 1) begin
                    coef_d[m] = sqrt_coef(3, 1);
                end else if (m > 1) begin
                    coef_d[m] = sqrt_coef(2 * m + 1, 2 * m);
                end
                coef_e[m] = sqrt_coef(2 * m + 3, 1);
                for (int n = 0; n <= MAX_DEGREE; n++) begin
                    coef_a[n][m] = 0;
                    coef_b[n][m] = 0;
                    if (n >= m + 2) begin
                        coef_a[n][m] = sqrt_coef((2 * n - 1) * (2 * n + 1),
                                                 (n - m) * (n + m));
                        coef_b[n][m] = sqrt_coef((2 * n + 1) * (n + m - 1) * (n - m - 1),
                                                 (2 * n - 3) * (n + m) * (n - m));
                    end
                end
            end
        endfunction

        // Floor of the square root, two bits of the radicand per step.
        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > x) probe >>= 2;
            while (probe != 0) begin
                if (x >= root + probe) begin
                    x    = x - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe >>= 2;
            end
            return root;
        endfunction

        // round(sqrt(num/den) * 2^COEF_FRAC), exact from the fraction.
        function longint sqrt_coef(longint unsigned num, longint unsigned den);
            longint unsigned quo;
            longint unsigned rem;
            longint unsigned rad;
            quo = num / den;
            rem = num % den;
            rad = quo;
            for (int i = 0; i < 2 * COEF_FRAC + 2; i++) begin
                rem = rem << 1;
                rad = rad << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    rad = rad | 64'd1;
                end
            end
            return $signed((floor_sqrt(rad) + 64'd1) >> 1);
        endfunction

        // Shift right with rounding to nearest, ties away from zero.
        function longint round_nearest(longint x, int sh);
            longint unsigned mag;
            mag = (x < 0) ? $unsigned(-x) : $unsigned(x);
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return (x < 0) ? -$signed(mag) : $signed(mag);
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function void set_top_degree(logic [DEG_W-1:0] value);
            top_degree = value;
        endfunction

        // Builds the table for one argument and queues it in emission order.
        function void note_argument(logic signed [ARG_W-1:0] arg);
            longint          diag [MAX_DEGREE+1];
            longint          t;
            longint          sine;
            longint          scale;
            longint          p;
            longint          p1;
            longint          p2;
            longint unsigned mag;
            int              top;
            t_table_entry    entry;

            top = int'(top_degree);
            if (top > MAX_DEGREE) top = MAX_DEGREE;

            t = longint'(arg);
            if (t > longint'(ARG_ONE)) t = longint'(ARG_ONE);
            if (t < -longint'(ARG_ONE)) t = -longint'(ARG_ONE);
            mag  = (t < 0) ? $unsigned(-t) : $unsigned(t);
            sine = $signed(floor_sqrt((64'd1 << (2 * ARG_FRAC_BITS)) - mag * mag));

            diag[0] = 64'sd1 << VALUE_FRAC_BITS;
            for (int m = 1; m <= top; m++) begin
                scale   = round_nearest(sine * coef_d[m], ARG_FRAC_BITS);
                diag[m] = clip32(round_nearest(scale * diag[m-1], COEF_FRAC));
            end

            for (int m = 0; m <= top; m++) begin
                p1 = 0;
                p2 = 0;
                for (int n = m; n <= top; n++) begin
                    if (n == m) begin
                        p = diag[m];
                    end else if (n == m + 1) begin
                        scale = round_nearest(t * coef_e[m], ARG_FRAC_BITS);
                        p     = clip32(round_nearest(scale * p1, COEF_FRAC));
                    end else begin
                        scale = round_nearest(t * coef_a[n][m], ARG_FRAC_BITS);
                        p     = clip32(round_nearest(scale * p1 - coef_b[n][m] * p2,
                                                     COEF_FRAC));
                    end
                    entry.degree = DEG_W'(n);
                    entry.order  = DEG_W'(m);
                    entry.value  = VAL_W'(p);
                    entry.last   = (m == top) && (n == top);
                    expected_values.push_back(entry);
                    p2 = p1;
                    p1 = p;
                end
            end
        endfunction

        function void check_value(logic [DEG_W-1:0] degree, logic [DEG_W-1:0] order,
                                  logic signed [VAL_W-1:0] value, logic last);
            t_table_entry want;
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected value P(%0d,%0d) = %0d last %0b",
                             degree, order, value, last);
                end
                return;
            end
            want = expected_values.pop_front();
            if (degree !== want.degree || order !== want.order ||
                value !== want.value || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected P(%0d,%0d) = %0d last %0b, got P(%0d,%0d) = %0d last %0b",
                             want.degree, want.order, want.value, want.last,
                             degree, order, value, last);
                end
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function bit passed();
            if (expected_values.size() != 0) begin
                $display("%0d expected values never arrived", expected_values.size());
            end
            return (mismatches == 0) && (expected_values.size() == 0);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the device under test.
    // ------------------------------------------------------------------------
    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DEG_W-1:0] i_cfg_wdata;

    nlt_in_if  arg_ch ();
    nlt_out_if val_ch ();

    normalized_legendre_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (arg_ch),
        .o_out       (val_ch)
    );

    legendre_scoreboard legendre_sb = new();

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The receiver decides its ready level at each falling edge, so stalls
    // land on every step of the emission sequence.
    always @(negedge i_clk) begin
        val_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every transfer on the output channel is checked at the rising edge
    // that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n && val_ch.valid && val_ch.ready) begin
            legendre_sb.check_value(val_ch.degree, val_ch.order, val_ch.value,
                                    val_ch.last);
        end
    end

    // Hard stop. The slowest legal run stays well below this, even with
    // every table at degree 9 and heavy stalling on both sides.
    initial begin
        #3_000_000;
        $display("tb_normalized_legendre_table: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks. All of them start and end at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one argument and holds it until the block takes it. Valid is
    // left high so that back-to-back arguments need no extra assignment.
    task automatic push_argument(input logic signed [ARG_W-1:0] arg);
        while ($urandom_range(99) < send_idle_pct) begin
            arg_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        arg_ch.valid    <= 1'b1;
        arg_ch.argument <= arg;
        do @(posedge i_clk); while (!arg_ch.ready);
        legendre_sb.note_argument(arg);
        @(negedge i_clk);
    endtask

    task automatic push_corners(input int first, input int final_idx);
        for (int k = first; k <= final_idx; k++) begin
            push_argument(CORNER_ARGS[k]);
        end
        arg_ch.valid <= 1'b0;
    endtask

    // Most arguments lie inside [-1, 1]; some sit just next to the edges or
    // zero, and some use the full 32-bit range so that clamping is hit and
    // every bit of the field toggles.
    task automatic push_random(input int count);
        logic signed [ARG_W-1:0] arg;
        longint                  offset;
        for (int k = 0; k < count; k++) begin
            offset = longint'($urandom_range(255));
            case ($urandom_range(9))
                0: arg = $urandom;
                1: arg = ARG_W'(longint'(ARG_ONE) - offset);
                2: arg = ARG_W'(offset - longint'(ARG_ONE));
                3: arg = ($urandom_range(1) == 0) ? ARG_W'(offset) : ARG_W'(-offset);
                default: arg = ARG_W'(longint'($urandom_range(32'h8000_0000))
                                      - longint'(ARG_ONE));
            endcase
            push_argument(arg);
        end
        arg_ch.valid <= 1'b0;
    endtask

    // The top degree may only change while the block is idle: wait for the
    // last value of the previous phase, then give it a few cycles.
    task automatic start_phase(input logic [DEG_W-1:0] top, input t_idle_mode mode);
        while (legendre_sb.pending() != 0) @(negedge i_clk);
        repeat (PAUSE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= top;
        @(posedge i_clk);
        legendre_sb.set_top_degree(top);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = HEAVY_IDLE_PCT;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = HEAVY_IDLE_PCT;
            end
            default: begin
                send_idle_pct  = LIGHT_IDLE_PCT;
                recv_stall_pct = LIGHT_IDLE_PCT;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        arg_ch.valid    = 1'b0;
        arg_ch.argument = '0;
        val_ch.ready    = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The corner arguments run first on the reset value of the top
        // degree, which is the full degree-9 table.
        push_corners(0, NUM_CORNERS - 1);

        // Degree zero: only P(0,0), which must carry the last flag.
        start_phase(4'd0, IDLE_NONE);
        push_corners(0, 2);
        push_random(20);

        // Degrees above the maximum must behave as the maximum.
        start_phase(4'd15, IDLE_SENDER);
        push_corners(7, 8);
        push_random(50);

        start_phase(4'd1, IDLE_RECEIVER);
        push_random(40);

        start_phase(4'd9, IDLE_BOTH);
        push_random(80);

        start_phase(4'd4, IDLE_NONE);
        push_random(50);

        start_phase(4'd10, IDLE_RECEIVER);
        push_random(50);

        start_phase(4'd2, IDLE_SENDER);
        push_random(40);

        start_phase(4'd9, IDLE_BOTH);
        push_random(70);

        // Drain, then watch for anything the block emits beyond the tables.
        while (legendre_sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (legendre_sb.passed()) begin
            $display("tb_normalized_legendre_table: PASS");
        end else begin
            $display("tb_normalized_legendre_table: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/nlt_pkg.sv
design/nlt_if.sv
design/nlt_datapath.sv
design/nlt_controller.sv
design/normalized_legendre_table.sv
dv/tb_normalized_legendre_table.sv
